@@ rtl/core/adjet_pkg.sv @@
// Shared constants, codes, types and helpers of the adjacency edge table.
package adjet_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_DEGREE   = 8;

	localparam int MODE_W     = 2;
	localparam int VTX_W      = 6;
	localparam int STATUS_W   = 3;
	localparam int TOTAL_W    = 10;
	localparam int VCNT_W     = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam int ROW_W    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int SLOT_W   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
	localparam int NB_DEPTH = MAX_VERTICES * MAX_DEGREE;
	localparam int NB_AW    = (NB_DEPTH > 1) ? $clog2(NB_DEPTH) : 1;
	localparam int LIM_W    = (ROW_W + 1 > VCNT_W) ? ROW_W + 1 : VCNT_W;

	localparam logic [DEG_W-1:0]   DEG_FULL   = DEG_W'(MAX_DEGREE);
	localparam logic [TOTAL_W-1:0] COUNT_MAX  = '1;
	localparam logic [LIM_W-1:0]   LIM_MAX    = LIM_W'(MAX_VERTICES);
	localparam logic [VCNT_W-1:0]  VCNT_RESET = VCNT_W'(64);

	typedef enum logic [MODE_W-1:0] {
		MODE_QUERY  = 2'd0,
		MODE_ADD    = 2'd1,
		MODE_REMOVE = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_RANGE   = 3'd1,
		ST_SELF    = 3'd2,
		ST_DUP     = 3'd3,
		ST_MISSING = 3'd4,
		ST_FULL    = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VERTEX_COUNT = 1'b0,
		CFG_DIRECTED     = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic             start;
		logic [ROW_W-1:0] row;
		logic [VTX_W-1:0] tgt;
		logic [DEG_W-1:0] len;
	} scan_req_t;

	typedef struct packed {
		logic              done;
		logic              hit;
		logic [SLOT_W-1:0] pos;
	} scan_rsp_t;

	typedef struct packed {
		logic             en;
		logic [NB_AW-1:0] addr;
	} nb_rd_t;

	function automatic logic [NB_AW-1:0] nb_addr(logic [ROW_W-1:0] row,
		logic [SLOT_W-1:0] slot);
		return NB_AW'(int'(row) * MAX_DEGREE + int'(slot));
	endfunction

	function automatic logic [ROW_W-1:0] to_row(logic [VTX_W-1:0] vtx);
		return ROW_W'(vtx);
	endfunction

endpackage

@@ rtl/core/adjet_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module adjet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/adjet_scan.sv @@
// Row scan unit: one neighbour compare per cycle against a target vertex.
module adjet_scan
	import adjet_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  scan_req_t        req,
	input  logic [VTX_W-1:0] rdata,
	output nb_rd_t           rd,
	output scan_rsp_t        rsp
);

	logic              active_q;
	logic              cmp_vld_q;
	logic [ROW_W-1:0]  row_q;
	logic [VTX_W-1:0]  tgt_q;
	logic [DEG_W-1:0]  len_q;
	logic [DEG_W-1:0]  iss_q;
	logic [SLOT_W-1:0] cmp_idx_q;
	logic              match;

	// Data read in the previous cycle is compared now while the next slot is fetched.
	assign match    = active_q && cmp_vld_q && (rdata == tgt_q);
	assign rsp.done = active_q && (match || (iss_q >= len_q));
	assign rsp.hit  = match;
	assign rsp.pos  = cmp_idx_q;
	assign rd.en    = active_q && !rsp.done && (iss_q < len_q);
	assign rd.addr  = nb_addr(row_q, iss_q[SLOT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			cmp_vld_q <= 1'b0;
		end else if (req.start) begin
			active_q  <= 1'b1;
			cmp_vld_q <= 1'b0;
		end else if (rsp.done) begin
			active_q  <= 1'b0;
			cmp_vld_q <= 1'b0;
		end else begin
			cmp_vld_q <= rd.en;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			row_q <= req.row;
			tgt_q <= req.tgt;
			len_q <= req.len;
			iss_q <= '0;
		end else if (rd.en) begin
			iss_q     <= iss_q + 1'b1;
			cmp_idx_q <= iss_q[SLOT_W-1:0];
		end
	end

endmodule

@@ rtl/core/adjacency_edge_table_unit.sv @@
// Adjacency edge table: request sequencer, degree and neighbour stores.
//
// Requests: a beat is taken on the edge where start is high and busy is low;
// mode, from_vertex and to_vertex are sampled there. busy stays high while
// the request is worked on and no new beat is taken meanwhile.
// Results: done is high for one cycle with found, status and edge_total;
// the receiver cannot stall, so each result is delivered as it appears.
// Sequence: a request with an out-of-range vertex gives done in the next
// cycle. Otherwise states DEG_U, DEG_V and DEG_W fetch the two degree counts
// and start the row scan; the source row is scanned one stored neighbour at
// a time until a match or its end. An add writes the source row and, when
// undirected, the target row. A remove moves the last neighbour of each row
// that holds the edge into its freed slot and, when undirected, scans the
// second row too. Scan and move share the single neighbour RAM read port.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the
// user must make them only while the block is idle, as the block does not check.
// Reset: degree valid bits and the edge count clear at once; neighbour RAM
// contents need no clearing, so the block is ready as soon as reset is released.
module adjacency_edge_table_unit
	import adjet_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [MODE_W-1:0]     mode,
	input  logic [VTX_W-1:0]      from_vertex,
	input  logic [VTX_W-1:0]      to_vertex,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic                  found,
	output logic [STATUS_W-1:0]   status,
	output logic [TOTAL_W-1:0]    edge_total
);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_DEG_U  = 12'b0000_0000_0010,
		S_DEG_V  = 12'b0000_0000_0100,
		S_DEG_W  = 12'b0000_0000_1000,
		S_SCAN_U = 12'b0000_0001_0000,
		S_APP_U  = 12'b0000_0010_0000,
		S_APP_V  = 12'b0000_0100_0000,
		S_LAST_U = 12'b0000_1000_0000,
		S_MOVE_U = 12'b0001_0000_0000,
		S_SCAN_V = 12'b0010_0000_0000,
		S_LAST_V = 12'b0100_0000_0000,
		S_MOVE_V = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	logic [VCNT_W-1:0]  vertex_count_q;
	logic               directed_q;
	logic [TOTAL_W-1:0] edge_count_q;
	logic [TOTAL_W-1:0] cnt_d;

	logic [MODE_W-1:0]  mode_q;
	logic [VTX_W-1:0]   u_q, v_q;
	logic [ROW_W-1:0]   u_row, v_row;
	logic [DEG_W-1:0]   deg_u_q, deg_v_q;
	logic               found_q;
	logic [SLOT_W-1:0]  pos_q;

	logic [LIM_W-1:0]   limit;
	logic               range_bad;

	logic                fin, fin_found, cnt_inc, cnt_dec;
	logic [STATUS_W-1:0] fin_status;

	logic [MAX_VERTICES-1:0] deg_vld_q;
	logic                    deg_rd_vld_q;
	logic                    deg_re, deg_we;
	logic [ROW_W-1:0]        deg_raddr, deg_waddr;
	logic [DEG_W-1:0]        deg_wdata, deg_rdata, deg_rd;

	logic               nb_we, nb_seq_re, nb_re;
	logic [NB_AW-1:0]   nb_waddr, nb_seq_raddr, nb_raddr;
	logic [VTX_W-1:0]   nb_wdata, nb_rdata;

	scan_req_t scan_req;
	scan_rsp_t scan_rsp;
	nb_rd_t    scan_rd;

	assign busy  = (state_q != S_IDLE);
	assign u_row = to_row(u_q);
	assign v_row = to_row(v_q);

	assign limit = (LIM_W'(vertex_count_q) > LIM_MAX) ? LIM_MAX : LIM_W'(vertex_count_q);
	assign range_bad = (LIM_W'(from_vertex) >= limit) || (LIM_W'(to_vertex) >= limit);

	// A row that was never written reads as degree zero.
	assign deg_rd = deg_rd_vld_q ? deg_rdata : '0;

	assign nb_re    = nb_seq_re || scan_rd.en;
	assign nb_raddr = nb_seq_re ? nb_seq_raddr : scan_rd.addr;

	always_comb begin
		state_d      = state_q;
		fin          = 1'b0;
		fin_found    = found_q;
		fin_status   = ST_OK;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		deg_re       = 1'b0;
		deg_raddr    = u_row;
		deg_we       = 1'b0;
		deg_waddr    = u_row;
		deg_wdata    = deg_u_q;
		nb_seq_re    = 1'b0;
		nb_seq_raddr = nb_addr(u_row, SLOT_W'(deg_u_q - 1'b1));
		nb_we        = 1'b0;
		nb_waddr     = nb_addr(u_row, pos_q);
		nb_wdata     = nb_rdata;
		scan_req.start = 1'b0;
		scan_req.row   = u_row;
		scan_req.tgt   = v_q;
		scan_req.len   = deg_u_q;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (range_bad) begin
						fin        = 1'b1;
						fin_found  = 1'b0;
						fin_status = ST_RANGE;
					end else begin
						state_d = S_DEG_U;
					end
				end
			end
			S_DEG_U: begin
				deg_re    = 1'b1;
				deg_raddr = u_row;
				state_d   = S_DEG_V;
			end
			S_DEG_V: begin
				deg_re    = 1'b1;
				deg_raddr = v_row;
				state_d   = S_DEG_W;
			end
			S_DEG_W: begin
				scan_req.start = 1'b1;
				state_d        = S_SCAN_U;
			end
			S_SCAN_U: begin
				if (scan_rsp.done) begin
					fin_found = scan_rsp.hit;
					case (mode_q)
						MODE_ADD: begin
							if (u_q == v_q) begin
								fin        = 1'b1;
								fin_status = ST_SELF;
							end else if (scan_rsp.hit) begin
								fin        = 1'b1;
								fin_status = ST_DUP;
							end else if ((deg_u_q >= DEG_FULL) ||
								(!directed_q && (deg_v_q >= DEG_FULL))) begin
								fin        = 1'b1;
								fin_status = ST_FULL;
							end else begin
								state_d = S_APP_U;
							end
						end
						MODE_REMOVE: begin
							if (scan_rsp.hit) begin
								state_d = S_LAST_U;
							end else if (!directed_q) begin
								scan_req.start = 1'b1;
								scan_req.row   = v_row;
								scan_req.tgt   = u_q;
								scan_req.len   = deg_v_q;
								state_d        = S_SCAN_V;
							end else begin
								fin        = 1'b1;
								fin_status = ST_MISSING;
							end
						end
						default: begin
							fin        = 1'b1;
							fin_status = scan_rsp.hit ? ST_OK : ST_MISSING;
						end
					endcase
				end
			end
			S_APP_U: begin
				nb_we     = 1'b1;
				nb_waddr  = nb_addr(u_row, deg_u_q[SLOT_W-1:0]);
				nb_wdata  = v_q;
				deg_we    = 1'b1;
				deg_waddr = u_row;
				deg_wdata = deg_u_q + 1'b1;
				if (directed_q) begin
					fin     = 1'b1;
					cnt_inc = 1'b1;
				end else begin
					state_d = S_APP_V;
				end
			end
			S_APP_V: begin
				nb_we     = 1'b1;
				nb_waddr  = nb_addr(v_row, deg_v_q[SLOT_W-1:0]);
				nb_wdata  = u_q;
				deg_we    = 1'b1;
				deg_waddr = v_row;
				deg_wdata = deg_v_q + 1'b1;
				fin       = 1'b1;
				cnt_inc   = 1'b1;
			end
			S_LAST_U: begin
				nb_seq_re    = 1'b1;
				nb_seq_raddr = nb_addr(u_row, SLOT_W'(deg_u_q - 1'b1));
				state_d      = S_MOVE_U;
			end
			S_MOVE_U: begin
				// Move the last neighbour into the freed slot and shrink the row.
				nb_we     = 1'b1;
				nb_waddr  = nb_addr(u_row, pos_q);
				nb_wdata  = nb_rdata;
				deg_we    = 1'b1;
				deg_waddr = u_row;
				deg_wdata = deg_u_q - 1'b1;
				if (!directed_q) begin
					scan_req.start = 1'b1;
					scan_req.row   = v_row;
					scan_req.tgt   = u_q;
					scan_req.len   = deg_v_q;
					state_d        = S_SCAN_V;
				end else begin
					fin     = 1'b1;
					cnt_dec = 1'b1;
				end
			end
			S_SCAN_V: begin
				if (scan_rsp.done) begin
					if (scan_rsp.hit) begin
						state_d = S_LAST_V;
					end else begin
						fin        = 1'b1;
						fin_status = found_q ? ST_OK : ST_MISSING;
						cnt_dec    = found_q;
					end
				end
			end
			S_LAST_V: begin
				nb_seq_re    = 1'b1;
				nb_seq_raddr = nb_addr(v_row, SLOT_W'(deg_v_q - 1'b1));
				state_d      = S_MOVE_V;
			end
			S_MOVE_V: begin
				nb_we      = 1'b1;
				nb_waddr   = nb_addr(v_row, pos_q);
				nb_wdata   = nb_rdata;
				deg_we     = 1'b1;
				deg_waddr  = v_row;
				deg_wdata  = deg_v_q - 1'b1;
				fin        = 1'b1;
				fin_status = found_q ? ST_OK : ST_MISSING;
				cnt_dec    = found_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (fin) begin
			state_d = S_IDLE;
		end
	end

	// Saturate at the top and hold at zero.
	always_comb begin
		cnt_d = edge_count_q;
		if (cnt_inc && (edge_count_q != COUNT_MAX)) begin
			cnt_d = edge_count_q + 1'b1;
		end else if (cnt_dec && (edge_count_q != '0)) begin
			cnt_d = edge_count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			done           <= 1'b0;
			edge_count_q   <= '0;
			deg_vld_q      <= '0;
			vertex_count_q <= VCNT_RESET;
			directed_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= fin;
			if (fin) begin
				edge_count_q <= cnt_d;
			end
			if (deg_we) begin
				deg_vld_q[deg_waddr] <= 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_VERTEX_COUNT: vertex_count_q <= cfg_data[VCNT_W-1:0];
					CFG_DIRECTED:     directed_q     <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q <= mode;
			u_q    <= from_vertex;
			v_q    <= to_vertex;
		end
		if (deg_re) begin
			deg_rd_vld_q <= deg_vld_q[deg_raddr];
		end
		if (state_q == S_DEG_V) begin
			deg_u_q <= deg_rd;
		end
		if (state_q == S_DEG_W) begin
			deg_v_q <= deg_rd;
		end
		if (state_q == S_SCAN_U && scan_rsp.done) begin
			found_q <= scan_rsp.hit;
		end
		if ((state_q == S_SCAN_U || state_q == S_SCAN_V) && scan_rsp.done) begin
			pos_q <= scan_rsp.pos;
		end
		if (fin) begin
			found      <= fin_found;
			status     <= fin_status;
			edge_total <= cnt_d;
		end
	end

	adjet_ram #(
		.WIDTH(DEG_W),
		.DEPTH(MAX_VERTICES)
	) u_deg_ram (
		.clk  (clk),
		.we   (deg_we),
		.waddr(deg_waddr),
		.wdata(deg_wdata),
		.re   (deg_re),
		.raddr(deg_raddr),
		.rdata(deg_rdata)
	);

	adjet_ram #(
		.WIDTH(VTX_W),
		.DEPTH(NB_DEPTH)
	) u_nb_ram (
		.clk  (clk),
		.we   (nb_we),
		.waddr(nb_waddr),
		.wdata(nb_wdata),
		.re   (nb_re),
		.raddr(nb_raddr),
		.rdata(nb_rdata)
	);

	adjet_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (scan_req),
		.rdata (nb_rdata),
		.rd    (scan_rd),
		.rsp   (scan_rsp)
	);

endmodule

@@ rtl/core/adjet_chk.sv @@
// Port-level checks of the adjacency edge table, bound to the top level.
module adjet_chk
	import adjet_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic [MODE_W-1:0]     mode,
	input logic [VTX_W-1:0]      from_vertex,
	input logic [VTX_W-1:0]      to_vertex,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  done,
	input logic                  found,
	input logic [STATUS_W-1:0]   status,
	input logic [TOTAL_W-1:0]    edge_total
);

	// An accepted beat either starts work or is rejected at once.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted request neither busy nor answered");

	a_finish_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request finished without a result beat");

	a_range_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_RANGE) |-> !found)
		else $error("out-of-range result reports an edge");

	a_dup_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_DUP) |-> found)
		else $error("duplicate result without the edge present");

endmodule

bind adjacency_edge_table_unit adjet_chk u_adjet_chk (.*);

@@ verif/adjacency_edge_table_unit_test.sv @@
// Self-checking testbench for the adjacency edge table unit.
module adjacency_edge_table_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import adjet_pkg::*;

	localparam int CYCLE_LIMIT = 1_200_000;
	localparam int MAX_REPORTS = 40;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct {
		logic                hit;
		status_t             st;
		logic [TOTAL_W-1:0]  total;
	} edge_result_t;

	typedef enum {PLAN_CHECKED, PLAN_TYPED, PLAN_REG} plan_kind_t;

	typedef struct {
		plan_kind_t          kind;
		logic [MODE_W-1:0]   m;
		logic [VTX_W-1:0]    u;
		logic [VTX_W-1:0]    v;
		edge_result_t        want;
		cfg_idx_t            reg_idx;
		int unsigned         reg_val;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [MODE_W-1:0]     mode = MODE_QUERY;
	logic [VTX_W-1:0]      from_vertex = '0;
	logic [VTX_W-1:0]      to_vertex = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_VERTEX_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  done;
	logic                  found;
	logic [STATUS_W-1:0]   status;
	logic [TOTAL_W-1:0]    edge_total;

	// Shadow of the table, the registers and the outstanding replies
	logic [VTX_W-1:0] nbr_row [MAX_VERTICES][MAX_DEGREE];
	int unsigned      nbr_deg [MAX_VERTICES];
	int unsigned      total_edges;
	int unsigned      cfg_vertices;
	bit               cfg_directed;
	int unsigned      capped_adds;
	edge_result_t     expected_replies [$];
	edge_result_t     no_pin;
	plan_row_t        plan [$];

	int unsigned fail_count;
	int unsigned report_count;
	int unsigned cycle_count;
	int unsigned calm_left;

	adjacency_edge_table_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.from_vertex(from_vertex),
		.to_vertex  (to_vertex),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.found      (found),
		.status     (status),
		.edge_total (edge_total)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("adjacency_edge_table_unit test failed");
			$finish;
		end
	end

	function automatic int row_slot(int unsigned row, logic [VTX_W-1:0] tgt);
		for (int i = 0; i < nbr_deg[row] && i < MAX_DEGREE; i++)
			if (nbr_row[row][i] == tgt)
				return i;
		return -1;
	endfunction

	function automatic void row_push(int unsigned row, logic [VTX_W-1:0] tgt);
		nbr_row[row][nbr_deg[row]] = tgt;
		nbr_deg[row]++;
	endfunction

	// Fill the freed slot with the last neighbour of the row
	function automatic bit row_drop(int unsigned row, logic [VTX_W-1:0] tgt);
		int pos;
		pos = row_slot(row, tgt);
		if (pos < 0)
			return 1'b0;
		nbr_row[row][pos] = nbr_row[row][nbr_deg[row] - 1];
		nbr_deg[row]--;
		return 1'b1;
	endfunction

	function automatic edge_result_t predict_request(logic [MODE_W-1:0] m,
		logic [VTX_W-1:0] u, logic [VTX_W-1:0] v);
		edge_result_t r;
		int unsigned  lim;
		bit           gone;
		lim = (cfg_vertices > MAX_VERTICES) ? MAX_VERTICES : cfg_vertices;
		r.hit = 1'b0;
		if (u >= lim || v >= lim) begin
			r.st = ST_RANGE;
		end else begin
			r.hit = (row_slot(u, v) >= 0);
			if (m == MODE_ADD) begin
				if (u == v) begin
					r.st = ST_SELF;
				end else if (r.hit) begin
					r.st = ST_DUP;
				end else if (nbr_deg[u] >= MAX_DEGREE ||
					(!cfg_directed && nbr_deg[v] >= MAX_DEGREE)) begin
					r.st = ST_FULL;
				end else begin
					row_push(u, v);
					if (!cfg_directed)
						row_push(v, u);
					if (total_edges < COUNT_MAX)
						total_edges++;
					else
						capped_adds++;
					r.st = ST_OK;
				end
			end else if (m == MODE_REMOVE) begin
				gone = row_drop(u, v);
				if (!cfg_directed)
					void'(row_drop(v, u));
				if (gone && total_edges > 0)
					total_edges--;
				r.st = gone ? ST_OK : ST_MISSING;
			end else begin
				r.st = r.hit ? ST_OK : ST_MISSING;
			end
		end
		r.total = TOTAL_W'(total_edges);
		return r;
	endfunction

	function automatic plan_row_t checked(logic [MODE_W-1:0] m, logic [VTX_W-1:0] u,
		logic [VTX_W-1:0] v);
		plan_row_t p;
		p.kind = PLAN_CHECKED;
		p.m = m;
		p.u = u;
		p.v = v;
		return p;
	endfunction

	function automatic plan_row_t typed(logic [MODE_W-1:0] m, logic [VTX_W-1:0] u,
		logic [VTX_W-1:0] v, logic hit, status_t st, int unsigned total);
		plan_row_t p;
		p = checked(m, u, v);
		p.kind = PLAN_TYPED;
		p.want.hit = hit;
		p.want.st = st;
		p.want.total = TOTAL_W'(total);
		return p;
	endfunction

	function automatic plan_row_t reg_write(cfg_idx_t idx, int unsigned val);
		plan_row_t p;
		p.kind = PLAN_REG;
		p.reg_idx = idx;
		p.reg_val = val;
		return p;
	endfunction

	// Mostly short gaps, a few long ones, and now and then a calm stretch
	function automatic int unsigned pick_gap();
		int unsigned p;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		p = $urandom_range(0, 99);
		if (p < 3) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (p < 45)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Hold start until the beat is taken; start stays high when no gap follows
	task automatic issue(logic [MODE_W-1:0] m, logic [VTX_W-1:0] u,
		logic [VTX_W-1:0] v, bit pinned, edge_result_t pin_val);
		edge_result_t predicted;
		int unsigned  gap;
		start <= 1'b1;
		mode <= m;
		from_vertex <= u;
		to_vertex <= v;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = predict_request(m, u, v);
		expected_replies.push_back(pinned ? pin_val : predicted);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			mode <= $urandom;
			from_vertex <= $urandom;
			to_vertex <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue_noise();
		issue($urandom_range(0, 3), $urandom, $urandom, 1'b0, no_pin);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (expected_replies.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int unsigned val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		// unused upper bits of the directed write carry noise
		if (idx == CFG_DIRECTED)
			cfg_data <= {6'($urandom), val[0]};
		else
			cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_data <= $urandom;
		if (idx == CFG_DIRECTED)
			cfg_directed = val[0];
		else
			cfg_vertices = val & 'h7F;
	endtask

	function automatic bit pick_new_edge(output logic [VTX_W-1:0] a,
		output logic [VTX_W-1:0] b);
		int unsigned r0, c0, r, c;
		r0 = $urandom_range(0, MAX_VERTICES - 1);
		for (int i = 0; i < MAX_VERTICES; i++) begin
			r = (r0 + i) % MAX_VERTICES;
			if (nbr_deg[r] < MAX_DEGREE) begin
				c0 = $urandom_range(0, MAX_VERTICES - 1);
				for (int j = 0; j < MAX_VERTICES; j++) begin
					c = (c0 + j) % MAX_VERTICES;
					if (c != r && row_slot(r, c) < 0) begin
						a = r;
						b = c;
						return 1'b1;
					end
				end
			end
		end
		return 1'b0;
	endfunction

	// Find an entry with no mirror: removing its reverse leaves the count alone
	function automatic bit pick_one_way(output logic [VTX_W-1:0] a,
		output logic [VTX_W-1:0] b);
		int unsigned      r0, r;
		logic [VTX_W-1:0] t;
		r0 = $urandom_range(0, MAX_VERTICES - 1);
		for (int i = 0; i < MAX_VERTICES; i++) begin
			r = (r0 + i) % MAX_VERTICES;
			for (int s = 0; s < nbr_deg[r]; s++) begin
				t = nbr_row[r][s];
				if (row_slot(t, r) < 0) begin
					a = t;
					b = r;
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	task automatic fill_rows();
		logic [VTX_W-1:0] a, b;
		int unsigned      extra;
		bit               ok;
		extra = 0;
		while (extra < 20) begin
			ok = pick_new_edge(a, b);
			if (!ok)
				extra++;
			if (ok && $urandom_range(0, 19) != 0)
				issue(MODE_ADD, a, b, 1'b0, no_pin);
			else
				issue_noise();
		end
	endtask

	task automatic clear_one_way();
		logic [VTX_W-1:0] a, b;
		int unsigned      extra;
		bit               ok;
		extra = 0;
		while (extra < 10) begin
			ok = pick_one_way(a, b);
			if (!ok)
				extra++;
			if (ok && $urandom_range(0, 19) != 0)
				issue(MODE_REMOVE, a, b, 1'b0, no_pin);
			else
				issue_noise();
		end
	endtask

	task automatic roam(int unsigned vc, bit dir, int unsigned beats);
		int unsigned       lim, p;
		logic [MODE_W-1:0] m;
		logic [VTX_W-1:0]  a, b;
		write_reg(CFG_VERTEX_COUNT, vc);
		write_reg(CFG_DIRECTED, dir);
		lim = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
		repeat (beats) begin
			p = $urandom_range(0, 99);
			m = (p < 35) ? MODE_REMOVE : (p < 70) ? MODE_ADD :
				(p < 90) ? MODE_QUERY : MODE_SPARE;
			if (lim > 0 && $urandom_range(0, 99) < 85) begin
				a = $urandom_range(0, lim - 1);
				b = $urandom_range(0, lim - 1);
			end else begin
				a = $urandom;
				b = $urandom;
			end
			issue(m, a, b, 1'b0, no_pin);
		end
	endtask

	task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
		fail_count++;
		if (report_count < MAX_REPORTS) begin
			report_count++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		edge_result_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_replies.size() == 0) begin
				flag_mismatch("unexpected reply, status", 0, status);
			end else begin
				want = expected_replies.pop_front();
				if (found !== want.hit)
					flag_mismatch("found", want.hit, found);
				if (status !== want.st)
					flag_mismatch("status", want.st, status);
				if (edge_total !== want.total)
					flag_mismatch("edge_total", want.total, edge_total);
			end
		end
	end

	initial begin
		foreach (nbr_deg[i])
			nbr_deg[i] = 0;
		total_edges = 0;
		cfg_vertices = VCNT_RESET;
		cfg_directed = 1'b0;

		plan.push_back(typed(MODE_QUERY, 0, 63, 1'b0, ST_MISSING, 0));
		plan.push_back(typed(MODE_ADD, 63, 63, 1'b0, ST_SELF, 0));
		plan.push_back(typed(MODE_ADD, 0, 63, 1'b0, ST_OK, 1));
		plan.push_back(typed(MODE_ADD, 0, 63, 1'b1, ST_DUP, 1));
		plan.push_back(typed(MODE_SPARE, 63, 0, 1'b1, ST_OK, 1));
		plan.push_back(typed(MODE_REMOVE, 63, 0, 1'b1, ST_OK, 0));
		plan.push_back(typed(MODE_REMOVE, 63, 0, 1'b0, ST_MISSING, 0));
		plan.push_back(typed(MODE_QUERY, 5, 5, 1'b0, ST_MISSING, 0));
		// drop both halves of a pair one at a time: the count must stop at zero
		plan.push_back(checked(MODE_ADD, 40, 41));
		plan.push_back(reg_write(CFG_DIRECTED, 1));
		plan.push_back(typed(MODE_REMOVE, 40, 41, 1'b1, ST_OK, 0));
		plan.push_back(typed(MODE_REMOVE, 41, 40, 1'b1, ST_OK, 0));
		plan.push_back(reg_write(CFG_DIRECTED, 0));
		for (int k = 2; k < 2 + MAX_DEGREE; k++)
			plan.push_back(checked(MODE_ADD, 1, k));
		plan.push_back(typed(MODE_ADD, 1, 10, 1'b0, ST_FULL, 8));
		plan.push_back(typed(MODE_ADD, 11, 1, 1'b0, ST_FULL, 8));
		plan.push_back(checked(MODE_REMOVE, 1, 4));
		plan.push_back(reg_write(CFG_DIRECTED, 1));
		plan.push_back(checked(MODE_ADD, 11, 1));
		plan.push_back(reg_write(CFG_DIRECTED, 0));
		// forward entry absent, reverse entry present
		plan.push_back(typed(MODE_REMOVE, 1, 11, 1'b0, ST_MISSING, 8));
		plan.push_back(typed(MODE_QUERY, 11, 1, 1'b0, ST_MISSING, 8));
		plan.push_back(reg_write(CFG_VERTEX_COUNT, 0));
		plan.push_back(checked(MODE_QUERY, 0, 0));
		plan.push_back(reg_write(CFG_VERTEX_COUNT, 1));
		plan.push_back(checked(MODE_ADD, 0, 0));
		plan.push_back(reg_write(CFG_VERTEX_COUNT, 127));
		plan.push_back(checked(MODE_ADD, 63, 62));
		plan.push_back(reg_write(CFG_VERTEX_COUNT, 64));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == PLAN_REG)
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			else
				issue(plan[i].m, plan[i].u, plan[i].v, plan[i].kind == PLAN_TYPED,
					plan[i].want);
		end

		// Pump the count: fill every row one way, strip the mirrors, repeat
		for (int round = 0; round < 3 && capped_adds == 0; round++) begin
			write_reg(CFG_DIRECTED, 1);
			fill_rows();
			if (capped_adds == 0) begin
				write_reg(CFG_DIRECTED, 0);
				clear_one_way();
			end
		end

		roam(2, 1'b1, 40);
		roam(5, 1'b0, 50);
		roam(0, 1'b1, 10);
		roam(127, 1'b0, 60);
		roam(33, 1'b1, 40);

		settle();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("adjacency_edge_table_unit test passed");
		else
			$display("adjacency_edge_table_unit test failed");
		$finish;
	end

endmodule
